// ===== design/pbc_pkg.sv =====
package pbc_pkg;

    localparam int PARTS        = 16;
    localparam int BLOCK_SHIFT  = 9;
    localparam int LABEL_SECTOR = 1;

    localparam int IDX_W   = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int SZ_W    = 21 - BLOCK_SHIFT;
    localparam int DVD_W   = 41;
    localparam int DVS_W   = 24;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EOF     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_RDONLY  = 2'd3;

    localparam logic [1:0] REG_SECTOR_SCALE = 2'd0;
    localparam logic [1:0] REG_SECS_PER_CYL = 2'd1;
    localparam logic [1:0] REG_RAW_OFFSET   = 2'd2;

    typedef struct packed {
        logic        func;
        logic [3:0]  part_index;
        logic [39:0] block_number;
        logic [19:0] byte_count;
        logic        is_read;
        logic        write_label_ok;
        logic [31:0] entry_offset;
        logic [31:0] entry_size;
    } pbc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] byte_count_out;
        logic [19:0] residual;
        logic [40:0] cylinder;
    } pbc_out_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] cnt;
        logic [19:0] res;
        logic        no_cyl;
    } pbc_meta_t;

endpackage

// ===== design/partition_bounds_check.sv =====
// partition bounds checker for disk transfer requests
// command channel: a word is taken at each rising edge with start high and
// busy low; busy is always low, so a word may be offered in every cycle
// func=1 words write one partition table entry and give an all-zero result
// func=0 words check a request against the addressed partition and give
// status, truncated count, residual and the cylinder of the absolute block
// each word gives exactly one result, shown for one cycle with done high,
// in the order taken
// throughput: one word per cycle; latency is set by four check stages and
// a 41-stage bit-per-stage pipelined divider for the cylinder
// a table write is seen by a request taken in the next cycle
// configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// the user writes registers only while no word is in flight (no check)
// reset: table cleared, sector_scale 1, secs_per_cyl 0, raw_offset 0,
// pipeline emptied
// the receiver cannot stall: results are shown once and not held
module partition_bounds_check
    import pbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pbc_in_t     item,
    output logic        done,
    output pbc_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [6:0]  scale_reg;
    logic [23:0] spc_reg;
    logic [31:0] raw_reg;

    logic [31:0] start_tab_reg [PARTS];
    logic [31:0] len_tab_reg   [PARTS];

    logic            acc;
    logic [6:0]      idx_wide;
    logic [IDX_W-1:0] idx;
    logic            idx_ok;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign acc       = start && !busy;
    assign idx_wide  = {3'd0, item.part_index};
    assign idx       = idx_wide[IDX_W-1:0];
    assign idx_ok    = {25'd0, idx_wide} < 32'(PARTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 7'd1;
            spc_reg   <= '0;
            raw_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SECTOR_SCALE: scale_reg <= cfg_data[6:0];
                REG_SECS_PER_CYL: spc_reg   <= cfg_data[23:0];
                REG_RAW_OFFSET:   raw_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PARTS; k++)
            begin
                start_tab_reg[k] <= '0;
                len_tab_reg[k]   <= '0;
            end
        end
        else if (acc && item.func && idx_ok)
        begin
            start_tab_reg[idx] <= item.entry_offset;
            len_tab_reg[idx]   <= item.entry_size;
        end
    end

    // stage 1: table read
    logic        v1_reg, func1_reg, bad1_reg, rd1_reg, wok1_reg;
    logic [39:0] blk1_reg;
    logic [19:0] cnt1_reg;
    logic [31:0] st1_reg, len1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        func1_reg <= item.func;
        bad1_reg  <= (spc_reg == '0) || !idx_ok;
        rd1_reg   <= item.is_read;
        wok1_reg  <= item.write_label_ok;
        blk1_reg  <= item.block_number;
        cnt1_reg  <= item.byte_count;
        st1_reg   <= start_tab_reg[idx];
        len1_reg  <= len_tab_reg[idx];
    end

    // stage 2: scaling
    logic            v2_reg, func2_reg, bad2_reg, rd2_reg, wok2_reg;
    logic [39:0]     blk2_reg;
    logic [19:0]     cnt2_reg;
    logic [SZ_W-1:0] sz2_reg;
    logic [38:0]     limit2_reg, base2_reg;
    logic [39:0]     label2_reg;
    logic [20:0]     cnt_round;

    assign cnt_round = {1'b0, cnt1_reg} + 21'((1 << BLOCK_SHIFT) - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        func2_reg  <= func1_reg;
        bad2_reg   <= bad1_reg;
        rd2_reg    <= rd1_reg;
        wok2_reg   <= wok1_reg;
        blk2_reg   <= blk1_reg;
        cnt2_reg   <= cnt1_reg;
        sz2_reg    <= cnt_round[20:BLOCK_SHIFT];
        limit2_reg <= 39'(len1_reg) * 39'(scale_reg);
        base2_reg  <= 39'(st1_reg) * 39'(scale_reg);
        label2_reg <= {1'b0, 39'(raw_reg) * 39'(scale_reg)} + 40'(LABEL_SECTOR);
    end

    // stage 3: bounds
    logic            v3_reg, fin3_reg, rd3_reg, wok3_reg, nocyl3_reg;
    logic [1:0]      st3_reg;
    logic [19:0]     cnt3_reg, res3_reg;
    logic [SZ_W-1:0] sz3_reg;
    logic [40:0]     absb3_reg;
    logic [39:0]     label3_reg;
    logic [41:0]     end_blk;
    logic [39:0]     lim_ext;
    logic [39:0]     remain;
    logic [19:0]     trunc_cnt;
    logic            fin_n, nocyl_n;
    logic [1:0]      st_n;
    logic [19:0]     cnt_n, res_n;
    logic [SZ_W-1:0] sz_n;

    assign lim_ext   = {1'b0, limit2_reg};
    assign end_blk   = {2'b0, blk2_reg} + 42'(sz2_reg);
    assign remain    = lim_ext - blk2_reg;
    assign trunc_cnt = 20'({remain[SZ_W-1:0], {BLOCK_SHIFT{1'b0}}});

    always_comb
    begin
        fin_n   = 1'b0;
        nocyl_n = 1'b0;
        st_n    = ST_OK;
        cnt_n   = cnt2_reg;
        res_n   = '0;
        sz_n    = sz2_reg;
        if (func2_reg)
        begin
            fin_n   = 1'b1;
            nocyl_n = 1'b1;
            cnt_n   = '0;
        end
        else if (bad2_reg)
        begin
            fin_n = 1'b1;
            st_n  = ST_INVALID;
        end
        else if (end_blk > {2'b0, lim_ext})
        begin
            if (blk2_reg == lim_ext)
            begin
                fin_n = 1'b1;
                st_n  = ST_EOF;
                res_n = cnt2_reg;
            end
            else if (blk2_reg > lim_ext)
            begin
                fin_n = 1'b1;
                st_n  = ST_INVALID;
            end
            else
            begin
                sz_n  = remain[SZ_W-1:0];
                cnt_n = trunc_cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fin3_reg   <= fin_n;
        nocyl3_reg <= nocyl_n;
        st3_reg    <= st_n;
        cnt3_reg   <= cnt_n;
        res3_reg   <= res_n;
        sz3_reg    <= sz_n;
        rd3_reg    <= rd2_reg;
        wok3_reg   <= wok2_reg;
        absb3_reg  <= {1'b0, blk2_reg} + 41'(base2_reg);
        label3_reg <= label2_reg;
    end

    // stage 4: label protection
    logic        v4_reg;
    pbc_meta_t   meta4_reg;
    logic [40:0] absb4_reg;
    logic [41:0] abs_end;
    logic        hit_label;
    pbc_meta_t   meta_n;

    assign abs_end   = {1'b0, absb3_reg} + 42'(sz3_reg);
    assign hit_label = (absb3_reg <= {1'b0, label3_reg})
                       && ((LABEL_SECTOR == 0) || (abs_end > {2'b0, label3_reg}))
                       && !rd3_reg && !wok3_reg;

    always_comb
    begin
        meta_n.status = st3_reg;
        meta_n.cnt    = cnt3_reg;
        meta_n.res    = res3_reg;
        meta_n.no_cyl = nocyl3_reg || fin3_reg;
        if (!fin3_reg && hit_label)
        begin
            meta_n.status = ST_RDONLY;
            meta_n.no_cyl = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        meta4_reg <= meta_n;
        absb4_reg <= absb3_reg;
    end

    // cylinder division
    logic             dv_valid;
    logic [DVD_W-1:0] dv_q;
    pbc_meta_t        dv_meta;

    pbc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .dividend  (absb4_reg),
        .divisor   (spc_reg),
        .in_meta   (meta4_reg),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .out_meta  (dv_meta)
    );

    assign done                  = dv_valid;
    assign result.status         = dv_meta.status;
    assign result.byte_count_out = dv_meta.cnt;
    assign result.residual       = dv_meta.res;
    assign result.cylinder       = dv_meta.no_cyl ? '0 : dv_q;

endmodule

// ===== design/pbc_div.sv =====
module pbc_div
    import pbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  pbc_meta_t        in_meta,
    output logic             out_valid,
    output logic [DVD_W-1:0] quotient,
    output pbc_meta_t        out_meta
);

    logic             v_reg [DVD_W];
    logic [DVD_W-1:0] q_reg [DVD_W];
    logic [DVS_W-1:0] r_reg [DVD_W];
    pbc_meta_t        m_reg [DVD_W];

    genvar i;
    generate
        for (i = 0; i < DVD_W; i++)
        begin : g_stage
            logic             v_prev;
            logic [DVD_W-1:0] q_prev;
            logic [DVS_W-1:0] r_prev;
            pbc_meta_t        m_prev;
            logic [DVS_W:0]   trial;
            logic             ge;
            logic [DVS_W:0]   diff;

            if (i == 0)
            begin : g_first
                assign v_prev = in_valid;
                assign q_prev = dividend;
                assign r_prev = '0;
                assign m_prev = in_meta;
            end
            else
            begin : g_next
                assign v_prev = v_reg[i-1];
                assign q_prev = q_reg[i-1];
                assign r_prev = r_reg[i-1];
                assign m_prev = m_reg[i-1];
            end

            assign trial = {r_prev, q_prev[DVD_W-1]};
            assign ge    = trial >= {1'b0, divisor};
            assign diff  = trial - {1'b0, divisor};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else
                begin
                    v_reg[i] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                q_reg[i] <= {q_prev[DVD_W-2:0], ge};
                r_reg[i] <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                m_reg[i] <= m_prev;
            end
        end
    endgenerate

    assign out_valid = v_reg[DVD_W-1];
    assign quotient  = q_reg[DVD_W-1];
    assign out_meta  = m_reg[DVD_W-1];

endmodule
